[rtl/dot_matrix_scroll_frame_gen_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling marquee frame generator
// Shared shorthand for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef DOT_MATRIX_SCROLL_FRAME_GEN_MACROS_SVH
`define DOT_MATRIX_SCROLL_FRAME_GEN_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define DMSF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DMSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dmsf_pkg.sv]
// ----------------------------------------------------------------------------
// dmsf_pkg
// Shared widths, constants and reset values of the marquee frame generator.
// ----------------------------------------------------------------------------
package dmsf_pkg;

  localparam int ROWS_DEF     = 8;
  localparam int COLS_DEF     = 24;
  localparam int NUM_PATTERNS = 8;
  localparam int PAT_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int ROW_WORD_W   = 32;
  localparam int ROW_IDX_W    = 3;
  localparam int PHASE_W      = 6;

  localparam logic [ROW_WORD_W-1:0] ROW_SEL_BASE = 32'h0100_0000;

  typedef logic [PAT_W-1:0] pattern_t;

  // Reset contents of the pattern registers; they spell the default message.
  function automatic pattern_t pattern_reset(input logic [CFG_IDX_W-1:0] idx);
    pattern_t val;
    case (idx)
      3'd0:    val = 24'd15189957;
      3'd1:    val = 24'd14413805;
      3'd2:    val = 24'd15194069;
      3'd3:    val = 24'd16777213;
      3'd4:    val = 24'd8487899;
      3'd5:    val = 24'd16773059;
      3'd6:    val = 24'd14675931;
      3'd7:    val = 24'd12840899;
      default: val = '1;
    endcase
    return val;
  endfunction

endpackage

[rtl/dmsf_pattern_regs.sv]
// ----------------------------------------------------------------------------
// dmsf_pattern_regs
// Register file holding the active-low column pattern of each matrix row.
// ----------------------------------------------------------------------------
module dmsf_pattern_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dmsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmsf_pkg::PAT_W-1:0]          cfg_data,
  input  logic [dmsf_pkg::CFG_IDX_W-1:0]      rd_index,
  output dmsf_pkg::pattern_t                  rd_pattern
);

  dmsf_pkg::pattern_t pattern_r [dmsf_pkg::NUM_PATTERNS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dmsf_pkg::NUM_PATTERNS; i++) begin
        pattern_r[i] <= dmsf_pkg::pattern_reset(dmsf_pkg::CFG_IDX_W'(i));
      end
    end else if (cfg_we) begin
      pattern_r[cfg_index] <= cfg_data;
    end
  end

  assign rd_pattern = pattern_r[rd_index];

endmodule

[rtl/dmsf_row_shifter.sv]
// ----------------------------------------------------------------------------
// dmsf_row_shifter
// Computes the column bits of one row for a given scroll phase.
// ----------------------------------------------------------------------------
module dmsf_row_shifter #(
  parameter int COLS = dmsf_pkg::COLS_DEF
) (
  input  dmsf_pkg::pattern_t               pattern,
  input  logic [dmsf_pkg::PHASE_W-1:0]     phase,
  output dmsf_pkg::pattern_t               columns
);

  localparam dmsf_pkg::pattern_t COL_MASK =
    {dmsf_pkg::PAT_W{1'b1}} >> (dmsf_pkg::PAT_W - COLS);

  dmsf_pkg::pattern_t             lit;
  dmsf_pkg::pattern_t             moved;
  logic [dmsf_pkg::PHASE_W-1:0]   shamt;

  // The pattern is worked on in active-high form so that vacated columns
  // fill with zeros, then inverted back so they read as off.
  always_comb begin
    lit = ~pattern & COL_MASK;
    if (phase < dmsf_pkg::PHASE_W'(COLS)) begin
      shamt = dmsf_pkg::PHASE_W'(COLS - 1) - phase;
      moved = lit >> shamt;
    end else begin
      shamt = phase - dmsf_pkg::PHASE_W'(COLS);
      moved = (lit << shamt) & COL_MASK;
    end
    columns = ~moved & COL_MASK;
  end

endmodule

[rtl/dot_matrix_scroll_frame_gen.sv]
// ----------------------------------------------------------------------------
// dot_matrix_scroll_frame_gen
// Scroll-in / scroll-out frame generator for an active-low LED dot matrix.
// ----------------------------------------------------------------------------
// Every input beat is one animation tick. A beat with tick set produces one
// frame of ROWS row words (8 at the default size) on the output channel;
// the single output register delivers one row word per cycle while
// out_stall is low. The block stays busy until the last row word of the
// frame is loaded; a beat with tick clear produces nothing. The
// next tick is taken in the same cycle that the last row word of the current
// frame is loaded, so frames stream without a gap when the output side never
// stalls. Each row word carries the one-hot row select in bits 31..24 and the
// active-low column bits in bits 23..0; columns that the scroll has vacated
// read 1 (off). During phases 0 to COLS-1 the message slides in, during
// phases COLS to 2*COLS-1 it slides out, and the phase advances once per
// frame and wraps to 0. Pattern registers are written through the cfg port
// and must only be changed while no frame is in flight.
// ----------------------------------------------------------------------------
module dot_matrix_scroll_frame_gen #(
  parameter int ROWS = dmsf_pkg::ROWS_DEF,
  parameter int COLS = dmsf_pkg::COLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [dmsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmsf_pkg::PAT_W-1:0]            cfg_data,
  // Tick input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_tick,
  // Row word output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dmsf_pkg::ROW_WORD_W-1:0]       out_row_word,
  output logic [dmsf_pkg::ROW_IDX_W-1:0]        out_row_index,
  output logic [dmsf_pkg::PHASE_W-1:0]          out_frame_phase,
  output logic                                  out_last_row
);

  localparam int PHASE_COUNT = 2 * COLS;
  localparam logic [dmsf_pkg::ROW_IDX_W-1:0] LAST_ROW = dmsf_pkg::ROW_IDX_W'(ROWS - 1);
  localparam logic [dmsf_pkg::PHASE_W-1:0]   LAST_PHASE =
    dmsf_pkg::PHASE_W'(PHASE_COUNT - 1);

  // Frame sequencer state
  logic                               busy_r, busy_nxt;
  logic [dmsf_pkg::ROW_IDX_W-1:0]     row_r, row_nxt;
  logic [dmsf_pkg::PHASE_W-1:0]       fphase_r, fphase_nxt;
  logic [dmsf_pkg::PHASE_W-1:0]       scroll_phase_r, scroll_phase_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [dmsf_pkg::ROW_WORD_W-1:0]    out_row_word_r;
  logic [dmsf_pkg::ROW_IDX_W-1:0]     out_row_index_r;
  logic [dmsf_pkg::PHASE_W-1:0]       out_frame_phase_r;
  logic                               out_last_row_r;

  logic                               out_free;
  logic                               load;
  logic                               row_is_last;
  logic                               accept;
  logic [dmsf_pkg::PHASE_W-1:0]       phase_cur;
  dmsf_pkg::pattern_t                 pattern;
  dmsf_pkg::pattern_t                 columns;

  dmsf_pattern_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_index   (row_r),
    .rd_pattern (pattern)
  );

  dmsf_row_shifter #(
    .COLS (COLS)
  ) u_shift (
    .pattern (pattern),
    .phase   (fphase_r),
    .columns (columns)
  );

  // The output register takes a new word when it is empty or its word is
  // leaving this cycle.
  assign out_free    = !out_valid_r || !out_stall;
  assign load        = busy_r && out_free;
  assign row_is_last = (row_r == LAST_ROW);

  // A new tick may enter while the last row of the current frame loads.
  assign in_stall = busy_r && !(load && row_is_last);
  assign accept   = in_valid && !in_stall;

  // A phase outside the legal range is read as phase zero.
  assign phase_cur = (scroll_phase_r >= dmsf_pkg::PHASE_W'(PHASE_COUNT)) ? '0 : scroll_phase_r;

  always_comb begin
    busy_nxt         = busy_r;
    row_nxt          = row_r;
    fphase_nxt       = fphase_r;
    scroll_phase_nxt = scroll_phase_r;

    if (load) begin
      row_nxt = row_r + 1'b1;
      if (row_is_last) begin
        busy_nxt = 1'b0;
      end
    end

    if (accept && in_tick) begin
      busy_nxt         = 1'b1;
      row_nxt          = '0;
      fphase_nxt       = phase_cur;
      scroll_phase_nxt = (phase_cur == LAST_PHASE) ? '0 : phase_cur + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      row_r          <= '0;
      fphase_r       <= '0;
      scroll_phase_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      row_r          <= row_nxt;
      fphase_r       <= fphase_nxt;
      scroll_phase_r <= scroll_phase_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload carries no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (load) begin
      out_row_word_r    <= (dmsf_pkg::ROW_SEL_BASE << row_r)
                         | dmsf_pkg::ROW_WORD_W'(columns);
      out_row_index_r   <= row_r;
      out_frame_phase_r <= fphase_r;
      out_last_row_r    <= row_is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_word    = out_row_word_r;
  assign out_row_index   = out_row_index_r;
  assign out_frame_phase = out_frame_phase_r;
  assign out_last_row    = out_last_row_r;

endmodule

[rtl/dmsf_checker.sv]
// ----------------------------------------------------------------------------
// dmsf_checker
// Port-level checks of the marquee frame generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "dot_matrix_scroll_frame_gen_macros.svh"

module dmsf_checker #(
  parameter int ROWS = dmsf_pkg::ROWS_DEF,
  parameter int COLS = dmsf_pkg::COLS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [dmsf_pkg::ROW_WORD_W-1:0]    out_row_word,
  input logic [dmsf_pkg::ROW_IDX_W-1:0]     out_row_index,
  input logic [dmsf_pkg::PHASE_W-1:0]       out_frame_phase,
  input logic                               out_last_row
);

  localparam logic [dmsf_pkg::ROW_IDX_W-1:0] LAST_ROW = dmsf_pkg::ROW_IDX_W'(ROWS - 1);
  localparam logic [dmsf_pkg::PHASE_W-1:0]   PHASE_END = dmsf_pkg::PHASE_W'(2 * COLS);

  logic [7:0] row_sel;
  assign row_sel = 8'h01 << out_row_index;

  // A stalled beat keeps its row word, row index and last flag.
  `DMSF_ASSERT(a_stall_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_row_word) && $stable(out_row_index) && $stable(out_last_row), "stalled row word changed")

  // Row select, row index and last flag agree, and the phase is legal.
  `DMSF_ASSERT(a_row_fields, clk, rst_n, out_valid |-> out_row_word[31:24] == row_sel && out_last_row == (out_row_index == LAST_ROW) && out_frame_phase < PHASE_END, "row word fields disagree")

  // Within a frame the next row follows directly with the same phase.
  `DMSF_ASSERT(a_frame_rows, clk, rst_n, out_valid && !out_stall && !out_last_row |=> out_valid && out_row_index == $past(out_row_index) + 1'b1 && out_frame_phase == $past(out_frame_phase), "frame rows not contiguous")

  // Nothing is offered in the cycle after reset.
  `DMSF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind dot_matrix_scroll_frame_gen dmsf_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_dmsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_row_word    (out_row_word),
  .out_row_index   (out_row_index),
  .out_frame_phase (out_frame_phase),
  .out_last_row    (out_last_row)
);
